// ===== src/c2ab_pkg.sv =====
// Shared constants, codes and types of the codec header to Annex-B converter.
`default_nettype none

package c2ab_pkg;

   // Sizing
   localparam int MaxExtradata = 4096;
   localparam int PrefixDepth  = 6;
   localparam int MaxBytes     = 6;
   localparam int CountW       = 3;
   localparam int SizeW        = 13;
   localparam logic [SizeW-1:0] SizeMax = 13'h1fff;

   // Codec codes as latched at the first header byte
   localparam logic [1:0] CodecH264 = 2'd0;
   localparam logic [1:0] CodecH265 = 2'd1;
   localparam logic [1:0] CodecCopy = 2'd2;

   // Register indexes
   localparam logic [0:0] CsrCodecSelect     = 1'b0;
   localparam logic [0:0] CsrStartcodeWindow = 1'b1;

   // Status codes of the summary result
   localparam logic [1:0] StatusOk      = 2'd0;
   localparam logic [1:0] StatusNoStart = 2'd1;
   localparam logic [1:0] StatusTrunc   = 2'd2;

   // Header constants
   localparam logic [3:0][7:0] StartCode = {8'h01, 8'h00, 8'h00, 8'h00};
   localparam logic [7:0] ConfigVersion  = 8'h01;
   localparam logic [7:0] ZeroByte       = 8'h00;
   localparam logic [4:0] SpsCountMask   = 5'h1f;
   localparam logic [2:0] DefaultLenSize = 3'd4;
   localparam logic [2:0] WindowMin      = 3'd1;
   localparam logic [2:0] WindowMax      = 3'd4;
   localparam logic [2:0] WindowReset    = 3'd4;
   localparam logic [7:0] SpsPpsGroups   = 8'd2;
   localparam int AvccSkipLast = 3;
   localparam int HvccSkipLast = 20;

   typedef enum logic [3:0] {
      PhIdle,
      PhSkip,
      PhLenSz,
      PhCount,
      PhAType,
      PhNumHi,
      PhNumLo,
      PhLenHi,
      PhLenLo,
      PhPayload,
      PhDone,
      PhSearch,
      PhPass,
      PhNoStart,
      PhCopy
   } phase_type;

   // All results caused by one request: bytes first, then the optional summary
   typedef struct packed {
      logic [CountW-1:0]            nbytes;
      logic [MaxBytes-1:0][7:0]     bytes;
      logic                         fin;
      logic [SizeW-1:0]             size;
      logic [2:0]                   len_size;
      logic [1:0]                   status;
   } bundle_type;

endpackage

`default_nettype wire

// ===== src/c2ab_parse.sv =====
// Header parser: per-byte state walk producing the result bundle of each request.
`default_nettype none

module c2ab_parse #(
   parameter int MAX_EXTRADATA = c2ab_pkg::MaxExtradata
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire logic [1:0]            codec_select,
   input  wire logic [2:0]            window,
   input  wire logic [7:0]            in_byte,
   input  wire logic                  in_last,
   output c2ab_pkg::bundle_type       bundle
);

   localparam int IdxW     = $clog2(MAX_EXTRADATA + 1);
   localparam int NumStore = c2ab_pkg::PrefixDepth - 1;

   // Parser state
   c2ab_pkg::phase_type phase_ff, phase_in;
   logic [1:0]          codec_ff, codec_in;
   logic [IdxW-1:0]     idx_ff, idx_in;
   logic [7:0]          arrays_ff, arrays_in;
   logic [15:0]         nals_ff, nals_in;
   logic [15:0]         payload_ff, payload_in;
   logic [7:0]          lenhi_ff, lenhi_in;
   logic [8:0]          held_ff, held_in;
   logic [c2ab_pkg::SizeW-1:0] size_ff, size_in;
   logic [2:0]          lensz_ff, lensz_in;

   // Annex-B prefix store and the two most recent search bytes
   logic [NumStore-1:0][7:0] pre_ff, pre_in;
   logic [7:0]          prev1_ff, prev1_in;
   logic [7:0]          prev2_ff, prev2_in;

   // Step temporaries
   logic [2:0]          win;
   logic                srch_full, srch_hit, srch_stop;
   logic [7:0]          grp_arrays;
   c2ab_pkg::phase_type grp_phase;
   logic [15:0]         nal_dec;
   logic [15:0]         count_v;
   logic                do_search;
   logic                closed;
   logic                use_size;
   logic [c2ab_pkg::CountW-1:0]         nb;
   logic [c2ab_pkg::MaxBytes-1:0][7:0]  bytes_v;
   logic [2:0]          fin_len;
   logic [1:0]          fin_status;
   logic [c2ab_pkg::SizeW:0]   size_sum;
   logic [c2ab_pkg::SizeW-1:0] size_sat;

   // Window clamp and start code search on the current byte
   always_comb begin
      if (window < c2ab_pkg::WindowMin) begin
         win = c2ab_pkg::WindowMin;
      end else if (window > c2ab_pkg::WindowMax) begin
         win = c2ab_pkg::WindowMax;
      end else begin
         win = window;
      end
   end

   assign srch_full = idx_ff >= IdxW'(c2ab_pkg::PrefixDepth);
   assign srch_hit  = (idx_ff >= IdxW'(2)) && (idx_ff < IdxW'(win) + IdxW'(2)) &&
                      (prev2_ff == c2ab_pkg::ZeroByte) && (prev1_ff == c2ab_pkg::ZeroByte) &&
                      (in_byte == 8'h01);
   assign srch_stop = idx_ff >= IdxW'(win) + IdxW'(1);

   // End of an array / parameter set group
   assign grp_arrays = arrays_ff - 8'd1;
   assign grp_phase  = (grp_arrays == 8'd0) ? c2ab_pkg::PhDone :
                       ((codec_ff == c2ab_pkg::CodecH265) ? c2ab_pkg::PhAType :
                                                            c2ab_pkg::PhCount);
   assign nal_dec    = nals_ff - 16'd1;

   // One header byte: walk, emit, and close on the last byte
   always_comb begin
      phase_in   = phase_ff;
      codec_in   = codec_ff;
      idx_in     = idx_ff;
      arrays_in  = arrays_ff;
      nals_in    = nals_ff;
      payload_in = payload_ff;
      lenhi_in   = lenhi_ff;
      held_in    = held_ff;
      lensz_in   = lensz_ff;
      pre_in     = pre_ff;
      prev1_in   = prev1_ff;
      prev2_in   = prev2_ff;
      count_v    = '0;
      do_search  = 1'b0;
      closed     = 1'b0;
      use_size   = 1'b0;
      nb         = '0;
      bytes_v    = '0;
      fin_len    = lensz_ff;
      fin_status = c2ab_pkg::StatusOk;

      if (idx_ff < IdxW'(MAX_EXTRADATA)) begin
         unique case (phase_ff)
            c2ab_pkg::PhIdle: begin
               if (codec_select >= c2ab_pkg::CodecCopy) begin
                  codec_in   = c2ab_pkg::CodecCopy;
                  phase_in   = c2ab_pkg::PhCopy;
                  bytes_v[0] = in_byte;
                  nb         = 3'd1;
               end else begin
                  codec_in = codec_select;
                  if (in_byte == c2ab_pkg::ConfigVersion) begin
                     phase_in = c2ab_pkg::PhSkip;
                  end else begin
                     phase_in  = c2ab_pkg::PhSearch;
                     do_search = 1'b1;
                  end
               end
            end
            c2ab_pkg::PhSkip: begin
               if (idx_ff >= ((codec_ff == c2ab_pkg::CodecH265) ?
                              IdxW'(c2ab_pkg::HvccSkipLast) :
                              IdxW'(c2ab_pkg::AvccSkipLast))) begin
                  phase_in = c2ab_pkg::PhLenSz;
               end
            end
            c2ab_pkg::PhLenSz: begin
               lensz_in = 3'(in_byte[1:0]) + 3'd1;
               if (codec_ff != c2ab_pkg::CodecH265) begin
                  arrays_in = c2ab_pkg::SpsPpsGroups;
               end
               phase_in = c2ab_pkg::PhCount;
            end
            c2ab_pkg::PhCount: begin
               if (codec_ff == c2ab_pkg::CodecH265) begin
                  arrays_in = in_byte;
                  phase_in  = (in_byte == 8'd0) ? c2ab_pkg::PhDone : c2ab_pkg::PhAType;
               end else begin
                  // SPS count lives in the low five bits
                  count_v = (arrays_ff == c2ab_pkg::SpsPpsGroups) ?
                            16'(in_byte[4:0] & c2ab_pkg::SpsCountMask) : 16'(in_byte);
                  nals_in = count_v;
                  if (count_v == 16'd0) begin
                     arrays_in = grp_arrays;
                     phase_in  = grp_phase;
                  end else begin
                     phase_in = c2ab_pkg::PhLenHi;
                  end
               end
            end
            c2ab_pkg::PhAType: begin
               phase_in = c2ab_pkg::PhNumHi;
            end
            c2ab_pkg::PhNumHi: begin
               lenhi_in = in_byte;
               phase_in = c2ab_pkg::PhNumLo;
            end
            c2ab_pkg::PhNumLo: begin
               nals_in = {lenhi_ff, in_byte};
               if ({lenhi_ff, in_byte} == 16'd0) begin
                  arrays_in = grp_arrays;
                  phase_in  = grp_phase;
               end else begin
                  phase_in = c2ab_pkg::PhLenHi;
               end
            end
            c2ab_pkg::PhLenHi: begin
               lenhi_in = in_byte;
               phase_in = c2ab_pkg::PhLenLo;
            end
            c2ab_pkg::PhLenLo: begin
               // length field becomes a four-byte start code
               payload_in = {lenhi_ff, in_byte};
               for (int k = 0; k < 4; k++) begin
                  bytes_v[k] = c2ab_pkg::StartCode[k];
               end
               nb = 3'd4;
               if ({lenhi_ff, in_byte} == 16'd0) begin
                  nals_in = nal_dec;
                  if (nal_dec == 16'd0) begin
                     arrays_in = grp_arrays;
                     phase_in  = grp_phase;
                  end else begin
                     phase_in = c2ab_pkg::PhLenHi;
                  end
               end else begin
                  phase_in = c2ab_pkg::PhPayload;
               end
            end
            c2ab_pkg::PhPayload: begin
               bytes_v[0] = in_byte;
               nb         = 3'd1;
               payload_in = payload_ff - 16'd1;
               if (payload_ff == 16'd1) begin
                  nals_in = nal_dec;
                  if (nal_dec == 16'd0) begin
                     arrays_in = grp_arrays;
                     phase_in  = grp_phase;
                  end else begin
                     phase_in = c2ab_pkg::PhLenHi;
                  end
               end
            end
            c2ab_pkg::PhSearch: begin
               do_search = 1'b1;
            end
            c2ab_pkg::PhPass: begin
               // one byte of delay so a trailing zero can be dropped
               bytes_v[0] = held_ff[7:0];
               nb         = 3'd1;
               held_in    = {1'b1, in_byte};
            end
            c2ab_pkg::PhCopy: begin
               bytes_v[0] = in_byte;
               nb         = 3'd1;
            end
            default: begin
            end
         endcase

         // Start code search over the leading bytes
         if (do_search) begin
            if (srch_full) begin
               phase_in = c2ab_pkg::PhNoStart;
            end else begin
               for (int k = 0; k < NumStore; k++) begin
                  if (idx_ff == IdxW'(k)) begin
                     pre_in[k] = in_byte;
                  end
               end
               prev2_in = prev1_ff;
               prev1_in = in_byte;
               if (srch_hit) begin
                  if (in_last && (idx_ff < IdxW'(3))) begin
                     closed     = 1'b1;
                     fin_len    = lensz_in;
                     fin_status = c2ab_pkg::StatusOk;
                  end else begin
                     for (int k = 0; k < NumStore; k++) begin
                        if (IdxW'(k) < idx_ff) begin
                           bytes_v[k] = pre_ff[k];
                        end
                     end
                     nb       = c2ab_pkg::CountW'(idx_ff);
                     held_in  = {1'b1, in_byte};
                     phase_in = c2ab_pkg::PhPass;
                  end
               end else if (srch_stop) begin
                  phase_in = c2ab_pkg::PhNoStart;
               end
            end
         end

         if (!closed) begin
            idx_in = idx_ff + IdxW'(1);
         end
      end

      // Close the header on the last byte
      if (in_last && !closed) begin
         closed  = 1'b1;
         fin_len = lensz_in;
         unique case (phase_in) inside
            c2ab_pkg::PhCopy, c2ab_pkg::PhDone: begin
               use_size   = 1'b1;
               fin_status = c2ab_pkg::StatusOk;
            end
            c2ab_pkg::PhPass: begin
               if (held_in[8] && !((codec_in == c2ab_pkg::CodecH264) &&
                                   (held_in[7:0] == c2ab_pkg::ZeroByte))) begin
                  bytes_v[nb] = held_in[7:0];
                  nb          = nb + 3'd1;
               end
               use_size   = 1'b1;
               fin_status = c2ab_pkg::StatusOk;
            end
            c2ab_pkg::PhSearch, c2ab_pkg::PhNoStart: begin
               fin_status = (idx_in > IdxW'(3)) ? c2ab_pkg::StatusNoStart :
                                                  c2ab_pkg::StatusOk;
            end
            c2ab_pkg::PhIdle: begin
               fin_status = c2ab_pkg::StatusOk;
            end
            c2ab_pkg::PhSkip: begin
               if (idx_in == IdxW'(1)) begin
                  fin_status = c2ab_pkg::StatusOk;
               end else begin
                  use_size   = 1'b1;
                  fin_status = c2ab_pkg::StatusTrunc;
               end
            end
            default: begin
               use_size   = 1'b1;
               fin_status = c2ab_pkg::StatusTrunc;
            end
         endcase
      end

      // Saturating byte count
      size_sum = {1'b0, size_ff} + (c2ab_pkg::SizeW + 1)'(nb);
      size_sat = (size_sum > (c2ab_pkg::SizeW + 1)'(c2ab_pkg::SizeMax)) ?
                 c2ab_pkg::SizeMax : size_sum[c2ab_pkg::SizeW-1:0];
      size_in  = size_sat;

      // Back to idle after the summary
      if (closed) begin
         phase_in   = c2ab_pkg::PhIdle;
         codec_in   = c2ab_pkg::CodecH264;
         idx_in     = '0;
         arrays_in  = '0;
         nals_in    = '0;
         payload_in = '0;
         lenhi_in   = '0;
         held_in    = '0;
         size_in    = '0;
         lensz_in   = c2ab_pkg::DefaultLenSize;
      end

      bundle.nbytes   = nb;
      bundle.bytes    = bytes_v;
      bundle.fin      = closed;
      bundle.size     = use_size ? size_sat : '0;
      bundle.len_size = fin_len;
      bundle.status   = fin_status;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= c2ab_pkg::PhIdle;
         codec_ff   <= c2ab_pkg::CodecH264;
         idx_ff     <= '0;
         arrays_ff  <= '0;
         nals_ff    <= '0;
         payload_ff <= '0;
         lenhi_ff   <= '0;
         held_ff    <= '0;
         size_ff    <= '0;
         lensz_ff   <= c2ab_pkg::DefaultLenSize;
      end else if (step) begin
         phase_ff   <= phase_in;
         codec_ff   <= codec_in;
         idx_ff     <= idx_in;
         arrays_ff  <= arrays_in;
         nals_ff    <= nals_in;
         payload_ff <= payload_in;
         lenhi_ff   <= lenhi_in;
         held_ff    <= held_in;
         size_ff    <= size_in;
         lensz_ff   <= lensz_in;
      end
   end

   // Prefix bytes, written before read
   always_ff @(posedge clock) begin
      if (step) begin
         pre_ff   <= pre_in;
         prev1_ff <= prev1_in;
         prev2_ff <= prev2_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/codec_header_to_annexb.sv =====
// Top level: codec header (avcC / hvcC / Annex-B) to Annex-B byte stream converter.
//
// Usage: header bytes enter one per request on req_ (req_in_last marks the final
// byte). Each request yields zero or more byte results on rsp_ (rsp_final_res = 0),
// and the final byte adds one summary result (rsp_final_res = 1) with the emitted
// size, the NAL length size and the status.
// Latency: the first result of a request is presented the cycle after it is
// accepted. Throughput is one request per cycle while each request yields at most
// one result and rsp_stall is low. A request yielding several results (up to seven:
// four start code bytes on a length field, or the buffered Annex-B prefix plus
// the summary) holds the result register until the last is taken, with req_stall
// high meanwhile. Requests yielding no result are taken while the register is free.
// Stall: while rsp_stall is high the pending result holds and req_stall stays high.
// Reset: codec_select returns to H.264, startcode_window to 4, the parser to idle
// and the result register empties. The user must write registers through csr_ only
// between headers (the block does not check); codec_select is read at header start.
`default_nettype none

module codec_header_to_annexb #(
   parameter int MAX_EXTRADATA = c2ab_pkg::MaxExtradata
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Configuration writes
   input  wire logic        csr_wr_en,
   input  wire logic [0:0]  csr_index,
   input  wire logic [2:0]  csr_wdata,
   // Header bytes in
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_in_last,
   // Results out
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_final_res,
   output logic [12:0]      rsp_header_size,
   output logic [2:0]       rsp_nal_length_size,
   output logic [1:0]       rsp_status
);

   // Configuration registers
   logic [1:0] codec_ff;
   logic [2:0] window_ff;

   // Result register: pending bytes then optional summary
   logic [c2ab_pkg::CountW-1:0]        nb_ff, nb_in;
   logic [c2ab_pkg::MaxBytes-1:0][7:0] bytes_ff, bytes_in;
   logic                               fin_ff, fin_in;
   logic [c2ab_pkg::SizeW-1:0]         fsize_ff;
   logic [2:0]                         flen_ff;
   logic [1:0]                         fstat_ff;

   c2ab_pkg::bundle_type bundle;
   logic has_byte;
   logic take;
   logic last_take;
   logic free;
   logic accept;

   c2ab_parse #(
      .MAX_EXTRADATA (MAX_EXTRADATA)
   ) u_parse (
      .clock        (clock),
      .reset        (reset),
      .step         (accept),
      .codec_select (codec_ff),
      .window       (window_ff),
      .in_byte      (req_in_byte),
      .in_last      (req_in_last),
      .bundle       (bundle)
   );

   // Configuration write decode
   always_ff @(posedge clock) begin
      if (reset) begin
         codec_ff  <= c2ab_pkg::CodecH264;
         window_ff <= c2ab_pkg::WindowReset;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            c2ab_pkg::CsrCodecSelect:     codec_ff  <= csr_wdata[1:0];
            c2ab_pkg::CsrStartcodeWindow: window_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Handshake: a new request loads once the last pending result leaves
   assign has_byte  = nb_ff != '0;
   assign rsp_valid = has_byte || fin_ff;
   assign take      = rsp_valid && !rsp_stall;
   assign last_take = take && (has_byte ? ((nb_ff == c2ab_pkg::CountW'(1)) && !fin_ff) : 1'b1);
   assign free      = !rsp_valid || last_take;
   assign req_stall = !free;
   assign accept    = req_valid && free;

   // Result register next value
   always_comb begin
      nb_in    = nb_ff;
      bytes_in = bytes_ff;
      fin_in   = fin_ff;
      if (accept) begin
         nb_in    = bundle.nbytes;
         bytes_in = bundle.bytes;
         fin_in   = bundle.fin;
      end else if (take) begin
         if (has_byte) begin
            nb_in    = nb_ff - c2ab_pkg::CountW'(1);
            bytes_in = bytes_ff >> 8;
         end else begin
            fin_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nb_ff  <= '0;
         fin_ff <= 1'b0;
      end else begin
         nb_ff  <= nb_in;
         fin_ff <= fin_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      if (accept) begin
         fsize_ff <= bundle.size;
         flen_ff  <= bundle.len_size;
         fstat_ff <= bundle.status;
      end
   end

   // Result fields: byte results carry zeros in the summary fields
   assign rsp_out_byte        = has_byte ? bytes_ff[0] : 8'h00;
   assign rsp_final_res       = !has_byte && fin_ff;
   assign rsp_header_size     = has_byte ? '0 : fsize_ff;
   assign rsp_nal_length_size = has_byte ? 3'd0 : flen_ff;
   assign rsp_status          = has_byte ? c2ab_pkg::StatusOk : fstat_ff;

   // Checks
   a_stall_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while a result is held");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      nb_ff <= c2ab_pkg::CountW'(c2ab_pkg::MaxBytes))
      else $error("pending byte count out of range");

   a_summary_drains: assert property (@(posedge clock) disable iff (reset)
      take && !has_byte && !accept |=> !rsp_valid)
      else $error("summary result repeated");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid == (($past(bundle.nbytes) != '0) || $past(bundle.fin)))
      else $error("loaded results not presented");

endmodule

`default_nettype wire
